// ----- hw/rtl/lbp_pkg.sv -----
package lbp_pkg;

   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int PIXEL_BITS  = 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [8:0][PIXEL_BITS-1:0] window_type;

   // input kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // register indexes (paddr[2])
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   // window index: row*3 + column, center at 4
   // bit 0 top-left, clockwise to bit 7 left
   function automatic pixel_type lbp_code(input window_type win, input border_type edge_at);
      pixel_type code;
      pixel_type ctr;
      ctr     = win[4];
      code[0] = !edge_at.top    && !edge_at.left  && (win[0] >= ctr);
      code[1] = !edge_at.top                      && (win[1] >= ctr);
      code[2] = !edge_at.top    && !edge_at.right && (win[2] >= ctr);
      code[3] = !edge_at.right                    && (win[5] >= ctr);
      code[4] = !edge_at.bottom && !edge_at.right && (win[8] >= ctr);
      code[5] = !edge_at.bottom                   && (win[7] >= ctr);
      code[6] = !edge_at.bottom && !edge_at.left  && (win[6] >= ctr);
      code[7] = !edge_at.left                     && (win[3] >= ctr);
      return code;
   endfunction

endpackage

// ----- hw/rtl/lbp_ram.sv -----
module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lbp_3x3_image_filter.sv -----
// output: the result for a pixel is registered on rsp by the transaction
//   that is image_width+1 items after that pixel (flush transactions drain the tail)
// throughput: one transaction per cycle while rsp is not stalled, limited by the line store read-modify-write
//   (read issued ahead at the next column, written back at the current column)
// reset: synchronous, clears counters, window and result valid; width and height
//   return to 1024; line stores are not cleared
module lbp_3x3_image_filter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [lbp_pkg::PIXEL_BITS-1:0]       req_pixel_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lbp_pkg::PIXEL_BITS-1:0]       rsp_pattern_code,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lbp_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lbp_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lbp_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import lbp_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > WIDTH_BITS) ? WW : WIDTH_BITS;

   logic [WIDTH_BITS-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic [CW-1:0]          in_col_ff, in_col_in;
   logic [HEIGHT_BITS-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]          out_col_ff, out_col_in;
   logic [HEIGHT_BITS-1:0] out_row_ff, out_row_in;
   logic                   frame_rcvd_ff, frame_rcvd_in;
   window_type             win_ff, win_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pixel_type              rsp_code_ff, rsp_code_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   fwd_hit_ff;
   pixel_type              upper_fwd_ff, middle_fwd_ff;

   logic [EW-1:0]          width_ext;
   logic [WW-1:0]          w_eff;
   logic [HEIGHT_BITS-1:0] h_last;
   logic                   csr_wr;
   logic                   accept, is_flush, proc, due;
   logic                   in_col_end, out_col_end, out_last;
   pixel_type              pix, upper_rd, middle_rd, top_px, mid_px;
   border_type             border;

   // effective frame size
   always_comb begin
      width_ext = EW'(image_width_ff);
      if (width_ext == '0) begin
         w_eff = WW'(1);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ext);
      end
      if (image_height_ff == '0) begin
         h_last = '0;
      end else begin
         h_last = image_height_ff - 1'b1;
      end
   end

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(image_width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(image_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_flush  = (req_kind == KIND_FLUSH);
   // pixels after a full frame and flushes before one leave no trace
   assign proc      = accept && (is_flush == frame_rcvd_ff);
   assign pix       = is_flush ? '0 : req_pixel_value;

   assign due = (in_row_ff >= HEIGHT_BITS'(2)) ||
                ((in_row_ff == HEIGHT_BITS'(1)) && (in_col_ff != '0));
   assign in_col_end  = ((WW+1)'(in_col_ff) + 1'b1) >= (WW+1)'(w_eff);
   assign out_col_end = ((WW+1)'(out_col_ff) + 1'b1) >= (WW+1)'(w_eff);
   assign out_last    = (out_row_ff >= h_last) && out_col_end;

   // read is issued ahead at the next column; a same-address write in the read's cycle is forwarded
   assign top_px = fwd_hit_ff ? upper_fwd_ff  : upper_rd;
   assign mid_px = fwd_hit_ff ? middle_fwd_ff : middle_rd;

   always_comb begin
      win_in = win_ff;
      if (proc) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = top_px;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid_px;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = pix;
      end
   end

   always_comb begin
      border.top    = (out_row_ff == '0);
      border.bottom = (out_row_ff >= h_last);
      border.left   = (out_col_ff == '0);
      border.right  = out_col_end;
   end

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      frame_rcvd_in   = frame_rcvd_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH:  image_width_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_in = csr_pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
         in_col_in     = '0;
         in_row_in     = '0;
         out_col_in    = '0;
         out_row_in    = '0;
         frame_rcvd_in = 1'b0;
      end else if (proc) begin
         if (!is_flush && (in_row_ff >= h_last) && in_col_end) begin
            frame_rcvd_in = 1'b1;
         end
         if (in_col_end) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (due) begin
            if (out_last) begin
               in_col_in     = '0;
               in_row_in     = '0;
               out_col_in    = '0;
               out_row_in    = '0;
               frame_rcvd_in = 1'b0;
            end else if (out_col_end) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (proc && due) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = lbp_code(win_in, border);
         rsp_last_in  = out_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_BITS'(1024);
         image_height_ff <= HEIGHT_BITS'(1024);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         frame_rcvd_ff   <= 1'b0;
         win_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         fwd_hit_ff      <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         frame_rcvd_ff   <= frame_rcvd_in;
         win_ff          <= win_in;
         rsp_valid_ff    <= rsp_valid_in;
         fwd_hit_ff      <= proc && (in_col_ff == in_col_in);
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
      upper_fwd_ff  <= mid_px;
      middle_fwd_ff <= pix;
   end

   lbp_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (proc),
      .wr_addr (in_col_ff),
      .wr_data (mid_px),
      .rd_addr (in_col_in),
      .rd_data (upper_rd)
   );

   lbp_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (proc),
      .wr_addr (in_col_ff),
      .wr_data (pix),
      .rd_addr (in_col_in),
      .rd_data (middle_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pattern_code = rsp_code_ff;
   assign rsp_frame_last   = rsp_last_ff;

endmodule

// ----- hw/rtl/lbp_checker.sv -----
module lbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pattern_code,
   input logic       rsp_frame_last,
   input logic       csr_pready
);

   // a held result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pattern_code) &&
                                  $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // a new result only follows an input transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without input transaction");

   // output register empty means input side open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr pready low");

endmodule

bind lbp_3x3_image_filter lbp_checker u_lbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pattern_code (rsp_pattern_code),
   .rsp_frame_last   (rsp_frame_last),
   .csr_pready       (csr_pready)
);
